### src/bop_pkg.sv
`timescale 1ns / 1ps
package bop_pkg;

  localparam int MAX_STEPS = 255;
  localparam int IDX_W     = $clog2(MAX_STEPS + 1);
  localparam int OPT_DEPTH = MAX_STEPS + 1;
  // one stock entry per lattice node, levels 0..MAX_STEPS
  localparam int STK_DEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
  localparam int STK_AW    = $clog2(STK_DEPTH);
  localparam int CFG_AW    = 3;

  localparam logic [16:0] Q16_ONE = 17'd65536;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SPOT = 3'd0,
    CFG_UP   = 3'd1,
    CFG_DOWN = 3'd2,
    CFG_PROB = 3'd3,
    CFG_DISC = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  steps;
    logic [31:0] strike;
    logic        is_put;
  } bop_in_t;

  typedef struct packed {
    logic [31:0] price;
    logic        exercise_now;
    logic        bad_steps;
  } bop_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_UP,
    ST_RD,
    ST_MUL,
    ST_MIX,
    ST_DSC,
    ST_WR,
    ST_DONE
  } bop_state_t;

  typedef struct packed {
    logic              req_ld;
    logic              row;
    logic              leaf;
    logic              up;
    logic              rd;
    logic              mul;
    logic              mix;
    logic              dsc;
    logic              wr;
    logic              root;
    logic              res_ld;
    logic              res_bad;
    logic [IDX_W-1:0]  idx;
    logic [STK_AW-1:0] stk_addr;
  } bop_cmd_t;

  function automatic logic [31:0] payoff(input logic put, input logic [31:0] k,
                                         input logic [31:0] s);
    logic [31:0] r;
    if (put) begin
      r = (k > s) ? (k - s) : 32'd0;
    end else begin
      r = (s > k) ? (s - k) : 32'd0;
    end
    return r;
  endfunction

endpackage

### src/bop_datapath.sv
`timescale 1ns / 1ps
module bop_datapath import bop_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [31:0]       cfg_data,
  input  bop_in_t           in_data,
  input  bop_cmd_t          cmd,
  output bop_out_t          res
);

  logic [31:0] spot_r, up_r, down_r;
  logic [16:0] prob_r, disc_r;
  logic        american_r, put_r;
  logic [31:0] strike_r;
  logic [31:0] u_r, x_r;
  logic [31:0] vdn_r, vup_r, stk_rd_r;
  logic [48:0] pq_r, pd_r, cd_r;
  logic [31:0] ex_r, mix_r;
  logic [31:0] root_r;
  logic        stop_r;
  bop_out_t    res_r;

  logic [31:0] opt_mem [OPT_DEPTH];
  logic [31:0] stk_mem [STK_DEPTH];

  logic [16:0] qc, qn, dc;
  logic [31:0] mul_a, mul_b, mres;
  logic [63:0] prod, rnd;
  logic [33:0] prod_q;
  logic [49:0] mixsum, cdsum;
  logic [31:0] cont, newv;
  logic        take_ex;
  logic [IDX_W-1:0] idx_up;

  assign qc = (prob_r > Q16_ONE) ? Q16_ONE : prob_r;
  assign dc = (disc_r > Q16_ONE) ? Q16_ONE : disc_r;
  assign qn = Q16_ONE - qc;

  // shared Q2.30 multiplier: down step along a row, up step between rows
  assign mul_a  = cmd.up ? u_r : x_r;
  assign mul_b  = cmd.up ? up_r : down_r;
  assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
  assign rnd    = prod + 64'd536870912;
  assign prod_q = rnd[63:30];
  assign mres   = (prod_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : prod_q[31:0];

  assign mixsum  = {1'b0, pq_r} + {1'b0, pd_r} + 50'd32768;
  assign cdsum   = {1'b0, cd_r} + 50'd32768;
  assign cont    = cdsum[47:16];
  assign take_ex = american_r && !(cont > ex_r);
  assign newv    = take_ex ? ex_r : cont;
  assign idx_up  = cmd.idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r <= 32'd6553600;
      up_r   <= 32'd1181116006;
      down_r <= 32'd966367642;
      prob_r <= 17'd32768;
      disc_r <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPOT: spot_r <= cfg_data;
        CFG_UP:   up_r   <= cfg_data;
        CFG_DOWN: down_r <= cfg_data;
        CFG_PROB: prob_r <= cfg_data[16:0];
        CFG_DISC: disc_r <= cfg_data[16:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      american_r <= in_data.cmd;
      put_r      <= in_data.is_put;
      strike_r   <= in_data.strike;
      u_r        <= spot_r;
      x_r        <= spot_r;
    end
    if (cmd.row) begin
      x_r <= mres;
    end
    if (cmd.up) begin
      u_r <= mres;
      x_r <= mres;
    end
    if (cmd.mul) begin
      pq_r <= {32'd0, qc} * {17'd0, vup_r};
      pd_r <= {32'd0, qn} * {17'd0, vdn_r};
      ex_r <= payoff(put_r, strike_r, stk_rd_r);
    end
    if (cmd.mix) begin
      mix_r <= mixsum[47:16];
    end
    if (cmd.dsc) begin
      cd_r <= {17'd0, mix_r} * {32'd0, dc};
    end
    if (cmd.wr && cmd.root) begin
      root_r <= newv;
      stop_r <= take_ex && (ex_r != 32'd0);
    end
    if (cmd.res_ld) begin
      res_r.price        <= cmd.res_bad ? 32'd0 : root_r;
      res_r.exercise_now <= cmd.res_bad ? 1'b0 : stop_r;
      res_r.bad_steps    <= cmd.res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      opt_mem[cmd.idx] <= newv;
    end else if (cmd.row && cmd.leaf) begin
      opt_mem[cmd.idx] <= payoff(put_r, strike_r, x_r);
    end
    if (cmd.rd) begin
      vdn_r <= opt_mem[cmd.idx];
      vup_r <= opt_mem[idx_up];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row) begin
      stk_mem[cmd.stk_addr] <= x_r;
    end
    if (cmd.rd) begin
      stk_rd_r <= stk_mem[cmd.stk_addr];
    end
  end

  assign res = res_r;

endmodule

### src/bop_ctrl.sv
`timescale 1ns / 1ps
module bop_ctrl import bop_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_steps,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output bop_cmd_t   cmd
);

  bop_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, n_r, n_nxt, nsteps_r, nsteps_nxt;
  logic [STK_AW-1:0] tri_r, tri_nxt, tri_i_r, tri_i_nxt;
  logic              bad_r, bad_nxt, out_valid_r, out_valid_nxt;
  logic              acc, steps_bad, leaf, row_end, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign steps_bad = (in_steps == 8'd0) || (32'(in_steps) > 32'(MAX_STEPS));
  assign leaf      = (n_r == nsteps_r);
  assign row_end   = (i_r == n_r);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = steps_bad ? ST_DONE : ST_ROW;
      ST_ROW:  if (leaf) state_nxt = (i_r == nsteps_r) ? ST_RD : ST_UP;
      ST_UP:   state_nxt = ST_ROW;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_DSC;
      ST_DSC:  state_nxt = ST_WR;
      ST_WR:   state_nxt = (row_end && n_r == '0) ? ST_DONE : ST_RD;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    i_nxt      = i_r;
    n_nxt      = n_r;
    tri_nxt    = tri_r;
    tri_i_nxt  = tri_i_r;
    nsteps_nxt = nsteps_r;
    bad_nxt    = bad_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          i_nxt      = '0;
          n_nxt      = '0;
          tri_nxt    = '0;
          tri_i_nxt  = '0;
          nsteps_nxt = IDX_W'(in_steps);
          bad_nxt    = steps_bad;
        end
      end
      ST_ROW: begin
        if (!leaf) begin
          n_nxt   = n_r + IDX_W'(1);
          tri_nxt = tri_r + STK_AW'(n_r) + STK_AW'(1);
        end else if (i_r == nsteps_r) begin
          // start backward pass at level N-1
          i_nxt   = '0;
          n_nxt   = nsteps_r - IDX_W'(1);
          tri_nxt = tri_r - STK_AW'(nsteps_r);
        end
      end
      ST_UP: begin
        i_nxt     = i_r + IDX_W'(1);
        n_nxt     = i_r + IDX_W'(1);
        tri_i_nxt = tri_i_r + STK_AW'(i_r) + STK_AW'(1);
        tri_nxt   = tri_i_r + STK_AW'(i_r) + STK_AW'(1);
      end
      ST_WR: begin
        if (!row_end) begin
          i_nxt = i_r + IDX_W'(1);
        end else if (n_r != '0) begin
          i_nxt   = '0;
          n_nxt   = n_r - IDX_W'(1);
          tri_nxt = tri_r - STK_AW'(n_r);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (state_r == ST_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd          = '0;
    cmd.idx      = i_r;
    cmd.stk_addr = tri_r + STK_AW'(i_r);
    cmd.leaf     = leaf;
    cmd.root     = (n_r == '0);
    cmd.res_bad  = bad_r;
    case (state_r)
      ST_IDLE: cmd.req_ld = acc;
      ST_ROW:  cmd.row    = 1'b1;
      ST_UP:   cmd.up     = 1'b1;
      ST_RD:   cmd.rd     = 1'b1;
      ST_MUL:  cmd.mul    = 1'b1;
      ST_MIX:  cmd.mix    = 1'b1;
      ST_DSC:  cmd.dsc    = 1'b1;
      ST_WR:   cmd.wr     = 1'b1;
      ST_DONE: cmd.res_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    tri_r    <= tri_nxt;
    tri_i_r  <= tri_i_nxt;
    nsteps_r <= nsteps_nxt;
  end

endmodule

### src/binomial_option_pricer.sv
`timescale 1ns / 1ps
// Binomial lattice option pricer (European or American, call or put) in
// fixed point. One request is priced at a time. After a request is taken the
// block first walks the lattice forward, one node per cycle apart from an up
// step between rows, filling a 32896-entry stock price memory through a
// single shared Q2.30 multiplier and writing the leaf payoffs. It then runs
// backward induction one node at a time, each node passing through read, mix
// products, mix sum, discount product, and select and write. A bad step count
// skips the lattice and goes straight to the result.
// The result sits in an output register, so the next request can be taken
// while the previous result waits. Configuration is taken at any time but
// must only be written while the block is idle; cfg_ready is always high.
module binomial_option_pricer import bop_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bop_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bop_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  bop_cmd_t cmd;
  logic     cfg_we;

  // registers are plain flops; accept every write
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: counters over lattice levels and nodes, handshakes
  bop_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_steps  (in_data.steps),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // arithmetic, memories and result register
  bop_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .res       (out_data)
  );

`ifndef NO_ASSERTIONS
  // a taken request blocks the input until its result is done
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a request was taken");

  // never overwrite a result that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  // a bad step count reports zero price and no exercise
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_steps) |->
      (out_data.price == 32'd0 && !out_data.exercise_now))
    else $error("bad step result carries price or exercise flag");
`endif

endmodule
